// File: sv/tbtd_pkg.sv
// Shared types, constants and opcodes for the timer bank with tick divider.
package tbtd_pkg;

  // Sizing
  localparam int CHANNELS    = 8;
  localparam int TICK_WIDTH  = 32;
  localparam int COUNTER_MAX = 255;

  localparam int CHAN_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W       = $clog2(COUNTER_MAX + 1);
  localparam int SW_BITS     = 8;            // stopwatch mask covers channels 0..7

  // Fixed field widths
  localparam int OP_W        = 3;
  localparam int CH_W        = 3;
  localparam int VAL_W       = 32;
  localparam int LOOP_W      = 16;
  localparam int HOME_W      = 8;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_DATA_W   = 40;           // 38 bits of fields, padded to bytes
  localparam int OUT_DATA_W  = 40;           // 35 bits of fields, padded to bytes

  localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(COUNTER_MAX);

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_LOOP_COUNT     = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_HOME_COUNT     = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_STOPWATCH_MASK = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 3'd0,
    OP_INIT  = 3'd1,
    OP_LOAD  = 3'd2,
    OP_START = 3'd3,
    OP_STOP  = 3'd4,
    OP_CLEAR = 3'd5,
    OP_READ  = 3'd6
  } op_t;

  // Addressed channel as seen after a step
  typedef struct packed {
    logic [TICK_WIDTH-1:0] ticks;
    logic                  running;
    logic                  finished;
  } chan_view_t;

endpackage

// File: sv/tbtd_divider.sv
// Base counter and overflow divider that produces the timer tick.
module tbtd_divider import tbtd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,        // one item processed this cycle
  input  logic [OP_W-1:0]   opcode,
  input  logic [LOOP_W-1:0] loop_count,
  input  logic [HOME_W-1:0] home_count,
  output logic              tick_fired   // valid with step
);

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [LOOP_W-1:0] idx_r, idx_nxt;
  logic              rem_r, rem_nxt;
  logic [CNT_W-1:0]  reload;
  logic [16:0]       home_ext;

  // Reload value, saturating at zero for a large home count
  assign home_ext = 17'(home_count);
  assign reload   = (home_ext > 17'(COUNTER_MAX)) ? '0
                                                  : CNT_W'(17'(COUNTER_MAX) - home_ext);

  always_comb begin
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    rem_nxt    = rem_r;
    tick_fired = 1'b0;
    case (op_t'(opcode))
      OP_TICK: begin
        if (cnt_r < CNT_TOP) begin
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          cnt_nxt = '0;
          if (idx_r == loop_count) begin
            if (rem_r) begin
              tick_fired = 1'b1;
              // restart the divider
              if (loop_count != '0) begin
                idx_nxt = '0;
                rem_nxt = 1'b0;
              end else begin
                rem_nxt = 1'b1;
                cnt_nxt = reload;
              end
            end else begin
              rem_nxt = 1'b1;
              cnt_nxt = reload;
            end
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      OP_INIT: begin
        if (loop_count != '0) begin
          idx_nxt = '0;
          rem_nxt = 1'b0;
        end else begin
          rem_nxt = 1'b1;
          cnt_nxt = reload;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
      rem_r <= 1'b0;
    end else if (step) begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule

// File: sv/tbtd_chan_bank.sv
// Channel bank: parallel countdown/stopwatch update and channel commands.
module tbtd_chan_bank import tbtd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic               timer_tick,   // from the divider, same cycle
  input  logic [OP_W-1:0]    opcode,
  input  logic [CH_W-1:0]    channel,
  input  logic [VAL_W-1:0]   load_value,
  input  logic [SW_BITS-1:0] stopwatch_mask,
  output chan_view_t         view          // addressed channel after the step
);

  logic [TICK_WIDTH-1:0] ticks_r   [CHANNELS];
  logic [TICK_WIDTH-1:0] ticks_nxt [CHANNELS];
  logic [CHANNELS-1:0]   run_r, run_nxt;
  logic [CHANNELS-1:0]   fin_r, fin_nxt;
  logic [CHANNELS-1:0]   is_sw;
  logic                  ch_ok;
  logic [CHAN_IDX_W-1:0] sel;
  logic [TICK_WIDTH-1:0] load_ext;

  assign ch_ok = (int'(channel) < CHANNELS);
  assign sel   = CHAN_IDX_W'(channel);

  generate
    if (TICK_WIDTH >= VAL_W) begin : g_load_wide
      assign load_ext = TICK_WIDTH'(load_value);
    end else begin : g_load_narrow
      assign load_ext = load_value[TICK_WIDTH-1:0];
    end
  endgenerate

  // Only the low channels have a stopwatch bit
  generate
    for (genvar i = 0; i < CHANNELS; i++) begin : g_sw
      if (i < SW_BITS) begin : g_bit
        assign is_sw[i] = stopwatch_mask[i];
      end else begin : g_none
        assign is_sw[i] = 1'b0;
      end
    end
  endgenerate

  always_comb begin
    ticks_nxt = ticks_r;
    run_nxt   = run_r;
    fin_nxt   = fin_r;
    // timer tick: every running channel moves one count
    if (timer_tick) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (run_r[i]) begin
          if (is_sw[i]) begin
            ticks_nxt[i] = ticks_r[i] + 1'b1;
          end else begin
            ticks_nxt[i] = ticks_r[i] - 1'b1;
            if (ticks_r[i] == TICK_WIDTH'(1)) begin
              run_nxt[i] = 1'b0;
              fin_nxt[i] = 1'b1;
            end
          end
        end
      end
    end
    // commands on the addressed channel
    if (ch_ok) begin
      case (op_t'(opcode))
        OP_LOAD: ticks_nxt[sel] = load_ext;
        OP_START: begin
          if (is_sw[sel]) begin
            run_nxt[sel] = 1'b1;
          end else if (ticks_r[sel] == '0) begin
            run_nxt[sel] = 1'b0;
            fin_nxt[sel] = 1'b1;
          end else begin
            run_nxt[sel] = 1'b1;
            fin_nxt[sel] = 1'b0;
          end
        end
        OP_STOP: run_nxt[sel] = 1'b0;
        OP_CLEAR: begin
          ticks_nxt[sel] = '0;
          run_nxt[sel]   = 1'b0;
          fin_nxt[sel]   = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        ticks_r[i] <= '0;
      end
      run_r <= '0;
      fin_r <= '0;
    end else if (step) begin
      ticks_r <= ticks_nxt;
      run_r   <= run_nxt;
      fin_r   <= fin_nxt;
    end
  end

  // report the addressed channel, zero when out of range
  always_comb begin
    if (ch_ok) begin
      view.ticks    = ticks_nxt[sel];
      view.running  = run_nxt[sel];
      view.finished = fin_nxt[sel];
    end else begin
      view = '0;
    end
  end

endmodule

// File: sv/timer_bank_with_tick_divider.sv
// Timer bank top: input register, divider, channel bank and result register.
// A beat is held in the input register, then its result beat in the result register.
// Throughput: one beat per cycle unless out_tready stalls the result; the step is a single
// pass of logic between input and result registers, and state is written as the step fires.
// Reset (rst_n low, synchronous): divider, channels, config and valid flags clear.
module timer_bank_with_tick_divider import tbtd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // opcode[2:0], channel[5:3], load_value[37:6], 0
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // tick_fired[0], channel_ticks[32:1],
                                            // channel_running[33], channel_finished[34], 0
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [LOOP_W-1:0]  loop_count_r;
  logic [HOME_W-1:0]  home_count_r;
  logic [SW_BITS-1:0] sw_mask_r;

  logic               in_valid_r;
  logic [OP_W-1:0]    in_op_r;
  logic [CH_W-1:0]    in_ch_r;
  logic [VAL_W-1:0]   in_val_r;

  logic               out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic               out_free;
  logic               step;
  logic               tick_fired;
  chan_view_t         view;
  logic [VAL_W-1:0]   view_ticks;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loop_count_r <= '0;
      home_count_r <= '0;
      sw_mask_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_LOOP_COUNT:     loop_count_r <= cfg_wdata[LOOP_W-1:0];
        CFG_HOME_COUNT:     home_count_r <= cfg_wdata[HOME_W-1:0];
        CFG_STOPWATCH_MASK: sw_mask_r    <= cfg_wdata[SW_BITS-1:0];
        default: ;
      endcase
    end
  end

  // handshake: result register frees when empty or taken
  assign out_free  = !out_valid_r || out_tready;
  assign step      = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_op_r  <= in_tdata[OP_W-1:0];
      in_ch_r  <= in_tdata[OP_W+CH_W-1:OP_W];
      in_val_r <= in_tdata[OP_W+CH_W+VAL_W-1:OP_W+CH_W];
    end
  end

  tbtd_divider u_divider (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .opcode     (in_op_r),
    .loop_count (loop_count_r),
    .home_count (home_count_r),
    .tick_fired (tick_fired)
  );

  tbtd_chan_bank u_chan_bank (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (step),
    .timer_tick     (tick_fired),
    .opcode         (in_op_r),
    .channel        (in_ch_r),
    .load_value     (in_val_r),
    .stopwatch_mask (sw_mask_r),
    .view           (view)
  );

  generate
    if (TICK_WIDTH >= VAL_W) begin : g_out_wide
      assign view_ticks = view.ticks[VAL_W-1:0];
    end else begin : g_out_narrow
      assign view_ticks = VAL_W'(view.ticks);
    end
  endgenerate

  assign out_data_nxt = OUT_DATA_W'({view.finished, view.running, view_ticks, tick_fired});

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
